@@ src/baro_temp_pressure_compensation_assert.svh @@
// Assertion macros for the compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BTPC_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define BTPC_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

@@ src/btpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Types and constants shared by the compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;
	localparam int unsigned NumRegs = 8;
	localparam int unsigned AddrW = 5;
	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StLimit = 2'd1;
	localparam logic [1:0] StDivZero = 2'd2;
	localparam logic [2:0] RegAc1Ac2 = 3'd0;
	localparam logic [2:0] RegAc3Ac4 = 3'd1;
	localparam logic [2:0] RegAc5Ac6 = 3'd2;
	localparam logic [2:0] RegB1B2 = 3'd3;
	localparam logic [2:0] RegMcMd = 3'd4;
	localparam logic [2:0] RegOss = 3'd5;
	localparam logic [2:0] RegLo = 3'd6;
	localparam logic [2:0] RegHi = 3'd7;

	// sequencer steps; each issues at most one datapath operation (the divider waits issue none)
	typedef enum logic [5:0] {
		S_IDLE,
		// temperature
		T_X1M, T_X1, T_DEN, T_DIVS, T_DIVW, T_B5, T_DIVS2, T_TOUT,
		// pressure
		P_B6, P_SQM, P_SQ, P_X1M, P_X1, P_X2M, P_X2, P_B3, P_A3M, P_A3,
		P_B1M, P_B1, P_X3, P_B4M, P_B4, P_B7M, P_B7, P_DIVS, P_DIVW, P_PQ,
		P_Q2M, P_Q2, P_Q3M, P_Q3, P_FIN,
		S_OUT
	} btpc_state_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_T_X1M, OP_T_X1, OP_T_DEN, OP_T_DIVS, OP_T_B5, OP_T_DIVS2,
		OP_T_TOUT, OP_P_B6, OP_P_SQM, OP_P_SQ, OP_P_X1M, OP_P_X1, OP_P_X2M,
		OP_P_X2, OP_P_B3, OP_P_A3M, OP_P_A3, OP_P_B1M, OP_P_B1, OP_P_X3,
		OP_P_B4M, OP_P_B4, OP_P_B7M, OP_P_B7, OP_P_DIVS, OP_P_PQ, OP_P_Q2M,
		OP_P_Q2, OP_P_Q3M, OP_P_Q3, OP_P_FIN, OP_LOAD
	} btpc_op_t;

	typedef struct packed {
		btpc_op_t op;
	} btpc_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic den_zero;
		logic b4_zero;
	} btpc_stat_t;

	typedef struct packed {
		logic [31:0] ac1_ac2;
		logic [31:0] ac3_ac4;
		logic [31:0] ac5_ac6;
		logic [31:0] b1_b2;
		logic [31:0] mc_md;
		logic [1:0]  oss;
		logic signed [7:0] lo;
		logic signed [7:0] hi;
	} btpc_cfg_t;

	function automatic logic signed [31:0] tdiv_p2(input logic signed [31:0] a,
			input int unsigned sh);
		logic signed [31:0] bias;
		bias = a[31] ? 32'sd1 <<< sh : 32'sd0;
		bias = a[31] ? bias - 32'sd1 : 32'sd0;
		return (a + bias) >>> sh;
	endfunction
endpackage

@@ src/btpc_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_stream_if
// Valid/ready channels for readings and results.
// ----------------------------------------------------------------------------
interface btpc_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [18:0] uncomp_value;
	modport source(output valid, action, uncomp_value, input ready);
	modport sink(input valid, action, uncomp_value, output ready);
endinterface

interface btpc_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic signed [31:0] compensated_value;
	logic [1:0]         status;
	modport source(output valid, result_kind, compensated_value, status, input ready);
	modport sink(input valid, result_kind, compensated_value, status, output ready);
endinterface

@@ src/btpc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_div
// Radix-2 restoring divider, unsigned 32 by 32, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module btpc_div import btpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [5:0]  cnt_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

@@ src/btpc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_datapath
// Shared multiplier, working registers and divider for the compensation.
// ----------------------------------------------------------------------------
module btpc_datapath import btpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  btpc_cmd_t          cmd,
	input  btpc_cfg_t          cfg,
	input  logic [18:0]        in_value,
	output btpc_stat_t         stat,
	output logic               res_kind,
	output logic signed [31:0] res_value,
	output logic [1:0]         res_status
);
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac5, ac6, ac4;
	logic signed [31:0] b5_q, b6_q, sq_q, x1_q, x2_q, b3_q, p_q, m_q, raw_q;
	logic [31:0] b4_q, b7_q;
	logic signed [31:0] ma, mb;
	logic        div_start, neg_q;
	logic [31:0] div_a, div_b, quo;
	logic        kind_q;
	logic signed [31:0] val_q, t, tq;
	logic [1:0]  st_q;
	logic signed [31:0] den, b3pre;
	logic [31:0] b4pre;
	logic [31:0] tmag, q10_q;
	logic [63:0] t10;

	assign ac1 = 32'(signed'(cfg.ac1_ac2[31:16]));
	assign ac2 = 32'(signed'(cfg.ac1_ac2[15:0]));
	assign ac3 = 32'(signed'(cfg.ac3_ac4[31:16]));
	assign ac4 = {16'd0, cfg.ac3_ac4[15:0]};
	assign ac5 = {16'd0, cfg.ac5_ac6[31:16]};
	assign ac6 = {16'd0, cfg.ac5_ac6[15:0]};
	assign b1 = 32'(signed'(cfg.b1_b2[31:16]));
	assign b2 = 32'(signed'(cfg.b1_b2[15:0]));
	assign mc = 32'(signed'(cfg.mc_md[31:16]));
	assign md = 32'(signed'(cfg.mc_md[15:0]));

	assign den = x1_q + md;
	assign b3pre = ((ac1 <<< 2) + x1_q + x2_q) <<< cfg.oss;
	assign b4pre = ac4 * b4_q;

	// multiplier operand selection; one 32x32 product registered per step
	always_comb begin
		ma = 32'sd0;
		mb = 32'sd0;
		case (cmd.op)
			OP_T_X1M: begin ma = raw_q - ac6; mb = ac5; end
			OP_P_SQM: begin ma = b6_q; mb = b6_q; end
			OP_P_X1M: begin ma = b2; mb = sq_q; end
			OP_P_X2M: begin ma = ac2; mb = b6_q; end
			OP_P_A3M: begin ma = ac3; mb = b6_q; end
			OP_P_B1M: begin ma = b1; mb = sq_q; end
			OP_P_B7M: begin ma = raw_q - b3_q; mb = 32'(50000 >> cfg.oss); end
			OP_P_Q2M: begin ma = tdiv_p2(p_q, 8); mb = tdiv_p2(p_q, 8); end
			OP_P_Q3M: begin ma = x1_q; mb = 32'sd3038; end
			default: begin ma = 32'sd0; mb = 32'sd0; end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_a = 32'd0;
		div_b = 32'd1;
		case (cmd.op)
			OP_T_DIVS: begin
				div_start = 1'b1;
				div_a = (mc[31] ? -mc : mc) << 11;
				div_b = den[31] ? 32'(-den) : 32'(den);
			end
			OP_P_DIVS: begin
				div_start = 1'b1;
				div_a = b7_q[31] ? b7_q : (b7_q << 1);
				div_b = b4_q;
			end
			default: ;
		endcase
	end

	assign t = (b5_q + 32'sd8) >>> 4;
	// |t| / 10 by reciprocal: floor(x * 0xCCCCCCCD / 2^35) is exact for 32-bit x
	assign tmag = t[31] ? 32'(-t) : 32'(t);
	assign t10 = {32'd0, tmag} * {32'd0, 32'hCCCC_CCCD};
	assign tq = neg_q ? -$signed(q10_q) : $signed(q10_q);

	btpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(stat.div_busy), .quotient(quo)
	);

	assign stat.den_zero = (den == 32'sd0);
	assign stat.b4_zero = (b4_q == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q <= 32'sd0;
		end else if (cmd.op == OP_T_B5) begin
			b5_q <= x1_q + (neg_q ? -$signed(quo) : $signed(quo));
		end
	end

	always_ff @(posedge clk) begin
		m_q <= ma * mb;
		case (cmd.op)
			OP_LOAD: raw_q <= {13'd0, in_value};
			OP_T_X1: x1_q <= m_q >>> 15;
			OP_T_DEN: begin
				if (stat.den_zero) begin
					kind_q <= 1'b0; val_q <= 32'sd0; st_q <= StDivZero;
				end
			end
			OP_T_DIVS: neg_q <= mc[31] ^ den[31];
			OP_T_DIVS2: begin
				neg_q <= t[31];
				q10_q <= {3'd0, t10[63:35]};
			end
			OP_T_TOUT: begin
				kind_q <= 1'b0;
				val_q <= tq;
				st_q <= (tq <= 32'(cfg.lo) || tq >= 32'(cfg.hi)) ? StLimit : StOk;
			end
			OP_P_B6: b6_q <= b5_q - 32'sd4000;
			OP_P_SQ: sq_q <= tdiv_p2(m_q, 12);
			OP_P_X1: x1_q <= tdiv_p2(m_q, 11);
			OP_P_X2: x2_q <= tdiv_p2(m_q, 11);
			OP_P_B3: b3_q <= tdiv_p2(b3pre + 32'sd2, 2);
			OP_P_A3: x1_q <= tdiv_p2(m_q, 13);
			OP_P_B1: x2_q <= tdiv_p2(m_q, 16);
			OP_P_X3: b4_q <= 32'(tdiv_p2(x1_q + x2_q + 32'sd2, 2) + 32'sd32768);
			OP_P_B4: b4_q <= b4pre >> 15;
			OP_P_B7: b7_q <= m_q;
			OP_P_DIVS: begin
				neg_q <= b7_q[31];
				if (stat.b4_zero) begin
					kind_q <= 1'b1; val_q <= 32'sd0; st_q <= StDivZero;
				end
			end
			OP_P_PQ: p_q <= neg_q ? $signed(quo << 1) : $signed(quo);
			OP_P_Q2: x1_q <= m_q;
			OP_P_Q3: begin
				x1_q <= tdiv_p2(m_q, 16);
				x2_q <= tdiv_p2(-32'sd7357 * p_q, 16);
			end
			OP_P_FIN: begin
				kind_q <= 1'b1;
				val_q <= p_q + tdiv_p2(x1_q + x2_q + 32'sd3791, 4);
				st_q <= StOk;
			end
			default: ;
		endcase
	end

	assign res_kind = kind_q;
	assign res_value = val_q;
	assign res_status = st_q;
endmodule

@@ src/btpc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_ctrl
// Sequencer: steps the datapath through one reading and holds the result beat.
// ----------------------------------------------------------------------------
module btpc_ctrl import btpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_action,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  btpc_stat_t stat,
	output btpc_cmd_t  cmd
);
	btpc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = in_action ? P_B6 : T_X1M;
			T_X1M: state_d = T_X1;
			T_X1: state_d = T_DEN;
			T_DEN: state_d = stat.den_zero ? S_OUT : T_DIVS;
			T_DIVS: state_d = T_DIVW;
			T_DIVW: if (!stat.div_busy) state_d = T_B5;
			T_B5: state_d = T_DIVS2;
			T_DIVS2: state_d = T_TOUT;
			T_TOUT: state_d = S_OUT;
			P_B6: state_d = P_SQM;
			P_SQM: state_d = P_SQ;
			P_SQ: state_d = P_X1M;
			P_X1M: state_d = P_X1;
			P_X1: state_d = P_X2M;
			P_X2M: state_d = P_X2;
			P_X2: state_d = P_B3;
			P_B3: state_d = P_A3M;
			P_A3M: state_d = P_A3;
			P_A3: state_d = P_B1M;
			P_B1M: state_d = P_B1;
			P_B1: state_d = P_X3;
			P_X3: state_d = P_B4M;
			P_B4M: state_d = P_B4;
			P_B4: state_d = P_B7M;
			P_B7M: state_d = P_B7;
			P_B7: state_d = P_DIVS;
			P_DIVS: state_d = stat.b4_zero ? S_OUT : P_DIVW;
			P_DIVW: if (!stat.div_busy) state_d = P_PQ;
			P_PQ: state_d = P_Q2M;
			P_Q2M: state_d = P_Q2;
			P_Q2: state_d = P_Q3M;
			P_Q3M: state_d = P_Q3;
			P_Q3: state_d = P_FIN;
			P_FIN: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin in_ready = 1'b1; cmd.op = OP_LOAD; end
			T_X1M: cmd.op = OP_T_X1M;
			T_X1: cmd.op = OP_T_X1;
			T_DEN: cmd.op = OP_T_DEN;
			T_DIVS: cmd.op = OP_T_DIVS;
			T_B5: cmd.op = OP_T_B5;
			T_DIVS2: cmd.op = OP_T_DIVS2;
			T_TOUT: cmd.op = OP_T_TOUT;
			P_B6: cmd.op = OP_P_B6;
			P_SQM: cmd.op = OP_P_SQM;
			P_SQ: cmd.op = OP_P_SQ;
			P_X1M: cmd.op = OP_P_X1M;
			P_X1: cmd.op = OP_P_X1;
			P_X2M: cmd.op = OP_P_X2M;
			P_X2: cmd.op = OP_P_X2;
			P_B3: cmd.op = OP_P_B3;
			P_A3M: cmd.op = OP_P_A3M;
			P_A3: cmd.op = OP_P_A3;
			P_B1M: cmd.op = OP_P_B1M;
			P_B1: cmd.op = OP_P_B1;
			P_X3: cmd.op = OP_P_X3;
			P_B4M: cmd.op = OP_P_B4M;
			P_B4: cmd.op = OP_P_B4;
			P_B7M: cmd.op = OP_P_B7M;
			P_B7: cmd.op = OP_P_B7;
			P_DIVS: cmd.op = OP_P_DIVS;
			P_PQ: cmd.op = OP_P_PQ;
			P_Q2M: cmd.op = OP_P_Q2M;
			P_Q2: cmd.op = OP_P_Q2;
			P_Q3M: cmd.op = OP_P_Q3M;
			P_Q3: cmd.op = OP_P_Q3;
			P_FIN: cmd.op = OP_P_FIN;
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

@@ src/baro_temp_pressure_compensation.sv @@
`timescale 1ns / 1ps
// Each reading runs the sequencer from its input beat to its result beat; a zero
// divisor ends the sequence early.
// One reading at a time: the next beat is taken in the cycle after the result beat,
// and the wait on the serial divider dominates the time per reading.
// Reset: arst_n clears the sequencer, stored B5 and the registers to their defaults.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Barometric temperature and pressure compensation with APB register port.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_assert.svh"
module baro_temp_pressure_compensation import btpc_pkg::*; #(
	parameter int unsigned ADDR_W = AddrW
) (
	input  logic              clk,
	input  logic              arst_n,
	btpc_in_if.sink           in_ch,
	btpc_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	btpc_cfg_t  cfg_q;
	btpc_cmd_t  cmd;
	btpc_stat_t stat;
	logic [2:0] ridx;
	logic       in_range;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];
	assign in_range = (paddr[1:0] == 2'd0) && ((paddr >> 5) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ac1_ac2 <= 32'd0;
			cfg_q.ac3_ac4 <= 32'd0;
			cfg_q.ac5_ac6 <= 32'd0;
			cfg_q.b1_b2 <= 32'd0;
			cfg_q.mc_md <= 32'd0;
			cfg_q.oss <= 2'd1;
			cfg_q.lo <= -8'sd40;
			cfg_q.hi <= 8'sd85;
		end else if (psel && penable && pwrite && in_range) begin
			case (ridx)
				RegAc1Ac2: cfg_q.ac1_ac2 <= pwdata;
				RegAc3Ac4: cfg_q.ac3_ac4 <= pwdata;
				RegAc5Ac6: cfg_q.ac5_ac6 <= pwdata;
				RegB1B2: cfg_q.b1_b2 <= pwdata;
				RegMcMd: cfg_q.mc_md <= pwdata;
				RegOss: cfg_q.oss <= pwdata[1:0];
				RegLo: cfg_q.lo <= pwdata[7:0];
				RegHi: cfg_q.hi <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		case (ridx)
			RegAc1Ac2: prdata = cfg_q.ac1_ac2;
			RegAc3Ac4: prdata = cfg_q.ac3_ac4;
			RegAc5Ac6: prdata = cfg_q.ac5_ac6;
			RegB1B2: prdata = cfg_q.b1_b2;
			RegMcMd: prdata = cfg_q.mc_md;
			RegOss: prdata = {30'd0, cfg_q.oss};
			RegLo: prdata = 32'(cfg_q.lo);
			RegHi: prdata = 32'(cfg_q.hi);
			default: prdata = 32'd0;
		endcase
		if (!in_range) prdata = 32'd0;
	end

	btpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_action(in_ch.action),
		.in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	btpc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg_q),
		.in_value(in_ch.uncomp_value), .stat(stat), .res_kind(out_ch.result_kind),
		.res_value(out_ch.compensated_value), .res_status(out_ch.status)
	);

	// no new reading while a result beat waits
	`BTPC_ASSERT_IMPL(a_excl, out_ch.valid, !in_ch.ready)
	`BTPC_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
	`BTPC_ASSERT_IMPL(a_stat, out_ch.valid, out_ch.status != 2'd3)
endmodule

@@ tb/sv/tb_baro_temp_pressure_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation
// Drives temperature and pressure readings through the compensation block
// under several calibration and limit settings, with random gaps on both
// channels, and checks every result beat against a local bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensation;
	import btpc_pkg::*;

	localparam int unsigned WdogLimit = 20000;
	localparam int unsigned SettleCycles = 200;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] value;
		logic [1:0]         st;
	} comp_result_t;

	typedef struct {
		logic        act;
		logic [18:0] raw;
		logic        has_exp;
		logic signed [31:0] exp_value;
		logic [1:0]  exp_st;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	btpc_in_if  in_ch();
	btpc_out_if out_ch();

	baro_temp_pressure_compensation dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of the register file and stored B5
	btpc_cfg_t cfg_m;
	logic signed [31:0] b5_m;
	comp_result_t expected_q[$];
	int unsigned err_count = 0;
	int unsigned idle_cycles = 0;
	bit no_gaps = 1'b0;
	bit tab_mode = 1'b0;
	stim_row_t typed_q[$];

	function automatic logic signed [31:0] tdiv32(logic signed [31:0] a,
			logic signed [31:0] b);
		if (a == 32'sh8000_0000 && b == -32'sd1)
			return a;
		return a / b;
	endfunction

	function automatic comp_result_t compensate(logic act, logic [18:0] raw);
		comp_result_t r;
		logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
		logic signed [31:0] x1, x2, x3, den, t, b6, sq, b3, p;
		logic [31:0] ac4, b4, b7, up, u;
		logic [1:0] oss;
		ac1 = 32'(signed'(cfg_m.ac1_ac2[31:16]));
		ac2 = 32'(signed'(cfg_m.ac1_ac2[15:0]));
		ac3 = 32'(signed'(cfg_m.ac3_ac4[31:16]));
		ac4 = {16'd0, cfg_m.ac3_ac4[15:0]};
		ac5 = {16'd0, cfg_m.ac5_ac6[31:16]};
		ac6 = {16'd0, cfg_m.ac5_ac6[15:0]};
		b1 = 32'(signed'(cfg_m.b1_b2[31:16]));
		b2 = 32'(signed'(cfg_m.b1_b2[15:0]));
		mc = 32'(signed'(cfg_m.mc_md[31:16]));
		md = 32'(signed'(cfg_m.mc_md[15:0]));
		oss = cfg_m.oss;
		r.kind = act;
		r.value = 0;
		r.st = StOk;
		if (!act) begin
			x1 = ((signed'({13'd0, raw}) - ac6) * ac5) >>> 15;
			den = x1 + md;
			if (den == 0) begin
				r.st = StDivZero;
				return r;
			end
			b5_m = x1 + tdiv32(mc * 2048, den);
			t = tdiv32((b5_m + 8) >>> 4, 10);
			r.value = t;
			if (t <= 32'(cfg_m.lo) || t >= 32'(cfg_m.hi))
				r.st = StLimit;
			return r;
		end
		b6 = b5_m - 4000;
		sq = tdiv32(b6 * b6, 4096);
		x3 = tdiv32(b2 * sq, 2048) + tdiv32(ac2 * b6, 2048);
		u = 32'((ac1 * 4 + x3) << oss) + 32'd2;
		b3 = tdiv32(signed'(u), 4);
		x3 = tdiv32(tdiv32(ac3 * b6, 8192) + tdiv32(b1 * sq, 65536) + 2, 4);
		b4 = (ac4 * 32'(x3 + 32768)) >> 15;
		b7 = ({13'd0, raw} - 32'(b3)) * (32'd50000 >> oss);
		if (b4 == 0) begin
			r.st = StDivZero;
			return r;
		end
		up = (b7 < 32'h8000_0000) ? (b7 * 2) / b4 : (b7 / b4) * 2;
		p = signed'(up);
		x1 = tdiv32(p, 256) * tdiv32(p, 256);
		x1 = tdiv32(x1 * 3038, 65536);
		x2 = tdiv32(-32'sd7357 * p, 65536);
		r.value = p + tdiv32(x1 + x2 + 3791, 16);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrW'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			RegAc1Ac2: cfg_m.ac1_ac2 = val;
			RegAc3Ac4: cfg_m.ac3_ac4 = val;
			RegAc5Ac6: cfg_m.ac5_ac6 = val;
			RegB1B2:   cfg_m.b1_b2 = val;
			RegMcMd:   cfg_m.mc_md = val;
			RegOss:    cfg_m.oss = val[1:0];
			RegLo:     cfg_m.lo = val[7:0];
			default:   cfg_m.hi = val[7:0];
		endcase
	endtask

	task automatic drain;
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_reading(logic act, logic [18:0] raw);
		int gap;
		if (!no_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.uncomp_value <= raw;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// predict at the accepted beat so the order matches the DUT
	always @(posedge clk) begin
		stim_row_t row;
		comp_result_t e;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			e = compensate(in_ch.action, in_ch.uncomp_value);
			if (tab_mode && typed_q.size() != 0) begin
				row = typed_q.pop_front();
				if (row.has_exp && (e.value != row.exp_value || e.st != row.exp_st))
					report_mismatch("typed row vs predictor", e.value, row.exp_value);
			end
			expected_q.push_back(e);
		end
	end

	always @(posedge clk) begin
		comp_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result beat", out_ch.compensated_value, 0);
			end else begin
				want = expected_q.pop_front();
				if (out_ch.result_kind !== want.kind)
					report_mismatch("result_kind", out_ch.result_kind, want.kind);
				if (out_ch.compensated_value !== want.value)
					report_mismatch("compensated_value", out_ch.compensated_value,
						want.value);
				if (out_ch.status !== want.st)
					report_mismatch("status", out_ch.status, want.st);
			end
		end
	end

	// sink back-pressure in bursts
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!no_gaps && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && idle_cycles >= WdogLimit) begin
			$display("baro_temp_pressure_compensation test failed");
			$finish;
		end
	end

	task automatic rand_cal;
		reg_write(RegAc1Ac2, $urandom());
		reg_write(RegAc3Ac4, $urandom());
		reg_write(RegAc5Ac6, $urandom());
		reg_write(RegB1B2, $urandom());
		reg_write(RegMcMd, $urandom());
	endtask

	// typical sensor calibration, so most readings hit realistic paths
	task automatic typical_cal;
		reg_write(RegAc1Ac2, {16'd408, 16'hFFC8});
		reg_write(RegAc3Ac4, {16'hC6D1, 16'd32741});
		reg_write(RegAc5Ac6, {16'd32757, 16'd23153});
		reg_write(RegB1B2, {16'd6190, 16'd4});
		reg_write(RegMcMd, {16'h8000, 16'd2868});
	endtask

	initial begin
		stim_row_t tab[$];
		stim_row_t r;
		int phase, i;
		logic [18:0] raw;
		cfg_m = '0;
		cfg_m.oss = 2'd1;
		cfg_m.lo = -8'sd40;
		cfg_m.hi = 8'sd85;
		b5_m = 0;
		in_ch.valid = 1'b0;
		in_ch.action = 1'b0;
		in_ch.uncomp_value = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset every calibration word is zero: temperature divisor is zero,
		// and pressure sees AC4 = 0 so B4 is zero
		r = '{1'b0, 19'd0, 1'b1, 32'sd0, StDivZero}; tab.push_back(r);
		r = '{1'b0, 19'h7FFFF, 1'b1, 32'sd0, StDivZero}; tab.push_back(r);
		r = '{1'b1, 19'd0, 1'b1, 32'sd0, StDivZero}; tab.push_back(r);
		r = '{1'b1, 19'h7FFFF, 1'b1, 32'sd0, StDivZero}; tab.push_back(r);
		tab_mode = 1'b1;
		foreach (tab[k]) begin
			typed_q.push_back(tab[k]);
			send_reading(tab[k].act, tab[k].raw);
		end
		in_ch.valid <= 1'b0;
		drain();
		tab_mode = 1'b0;

		typical_cal();
		// pressure before temperature, then typical and extreme words
		send_reading(1'b1, 19'd23843);
		send_reading(1'b0, 19'd27898);
		send_reading(1'b1, 19'd23843);
		send_reading(1'b0, 19'h7FFFF);
		send_reading(1'b0, 19'd0);
		send_reading(1'b1, 19'h7FFFF);
		send_reading(1'b1, 19'd0);
		send_reading(1'b0, 19'h0FFFF);
		send_reading(1'b0, 19'h55555);
		send_reading(1'b1, 19'h2AAAA);
		in_ch.valid <= 1'b0;
		drain();
		repeat (SettleCycles) @(negedge clk);

		// limits at extremes: everything flagged, then only values at or beyond -128 or 127
		reg_write(RegLo, 32'h7F);
		reg_write(RegHi, 32'h80);
		send_reading(1'b0, 19'd27898);
		in_ch.valid <= 1'b0;
		drain();
		reg_write(RegOss, 32'd0);
		reg_write(RegLo, 32'h80);
		reg_write(RegHi, 32'h7F);
		send_reading(1'b0, 19'd27898);
		send_reading(1'b1, 19'd40000);
		in_ch.valid <= 1'b0;
		drain();

		for (phase = 0; phase < 6; phase++) begin
			in_ch.valid <= 1'b0;
			drain();
			repeat (SettleCycles) @(negedge clk);
			if (phase == 5)
				no_gaps = 1'b1;
			if (phase == 2 || phase == 4)
				rand_cal();
			else
				typical_cal();
			reg_write(RegOss, phase % 4);
			reg_write(RegLo, phase == 3 ? 32'h80 : $urandom_range(0, 255));
			reg_write(RegHi, phase == 3 ? 32'h7F : $urandom_range(0, 255));
			for (i = 0; i < 150; i++) begin
				raw = $urandom_range(0, 3) == 0 ? 19'($urandom()) :
					19'($urandom_range(15000, 40000));
				send_reading(1'b1, raw);
				if (i == 100) begin
					in_ch.valid <= 1'b0;
					drain();
				end
				raw = $urandom_range(0, 3) == 0 ? 19'($urandom()) :
					19'($urandom_range(20000, 35000));
				if ($urandom_range(0, 2) != 0)
					send_reading(1'b0, raw);
			end
		end
		in_ch.valid <= 1'b0;
		drain();
		repeat (SettleCycles) @(negedge clk);
		if (err_count == 0)
			$display("baro_temp_pressure_compensation test passed");
		else
			$display("baro_temp_pressure_compensation test failed");
		$finish;
	end
endmodule
